>>> sv/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked every clock edge, held off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Property checked every clock edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

>>> sv/tbu_pkg.sv
// ----------------------------------------------------------------------------
// tbu_pkg
// Widths, constants and shared types of the triangle tangent basis unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tbu_pkg;

   localparam int COORD_BITS = 16;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int VEC_W      = 2 * DIFF_W + 1;
   localparam int MAG_W      = (VEC_W > 31) ? VEC_W : 31;
   localparam int MUL_W      = 32;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int NORM_W     = 30;
   localparam int L2_W       = 2 * NORM_W + 2;
   localparam int LEN_W      = NORM_W + 1;
   localparam int ONE_SHIFT  = 14;
   localparam int QUO_W      = ONE_SHIFT + 1;
   localparam int REM_W      = NORM_W + ONE_SHIFT + 2;
   localparam int OUT_W      = 16;
   localparam int ONE_Q14    = 1 << ONE_SHIFT;
   localparam int STEP_W     = 5;
   localparam int SQRT_TOP   = NORM_W;
   localparam int DIV_TOP    = QUO_W - 1;
   localparam int PIDX_W     = 4;
   localparam int PROD_LAST  = 13;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic signed [COORD_BITS-1:0] pos_z;
      logic        [COORD_BITS-1:0] tex_u;
      logic        [COORD_BITS-1:0] tex_v;
   } vertex_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] tangent_x;
      logic signed [OUT_W-1:0] tangent_y;
      logic signed [OUT_W-1:0] tangent_z;
      logic signed [OUT_W-1:0] bitangent_x;
      logic signed [OUT_W-1:0] bitangent_y;
      logic signed [OUT_W-1:0] bitangent_z;
      logic                    degenerate;
   } result_type;

   typedef struct packed {
      logic start;
      logic out_ready;
   } core_ctl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } core_stat_type;

   function automatic logic signed [COORD_BITS-1:0] pos_of(vertex_type v, int i);
      logic signed [COORD_BITS-1:0] p;
      case (i)
         0:       p = v.pos_x;
         1:       p = v.pos_y;
         default: p = v.pos_z;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

>>> sv/tbu_if.sv
// ----------------------------------------------------------------------------
// tbu_req_if / tbu_rsp_if
// Valid/ready channels carrying vertices in and tangent bases out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tbu_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [tbu_pkg::COORD_BITS-1:0] pos_x;
   logic signed [tbu_pkg::COORD_BITS-1:0] pos_y;
   logic signed [tbu_pkg::COORD_BITS-1:0] pos_z;
   logic        [tbu_pkg::COORD_BITS-1:0] tex_u;
   logic        [tbu_pkg::COORD_BITS-1:0] tex_v;

   modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface tbu_rsp_if;
   logic                            valid;
   logic                            ready;
   logic signed [tbu_pkg::OUT_W-1:0] tangent_x;
   logic signed [tbu_pkg::OUT_W-1:0] tangent_y;
   logic signed [tbu_pkg::OUT_W-1:0] tangent_z;
   logic signed [tbu_pkg::OUT_W-1:0] bitangent_x;
   logic signed [tbu_pkg::OUT_W-1:0] bitangent_y;
   logic signed [tbu_pkg::OUT_W-1:0] bitangent_z;
   logic                            degenerate;

   modport source (output valid, tangent_x, tangent_y, tangent_z, bitangent_x,
                   bitangent_y, bitangent_z, degenerate, input ready);
   modport sink   (input valid, tangent_x, tangent_y, tangent_z, bitangent_x,
                   bitangent_y, bitangent_z, degenerate, output ready);
endinterface

`default_nettype wire

>>> sv/triangle_tangent_basis_unit.sv
// ----------------------------------------------------------------------------
// triangle_tangent_basis_unit
// Per-triangle unit tangent and bitangent from three streamed vertices.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                  transfer
//  req_chan  in   pos_x/y/z Q1.14, tex_u/v Q0.16           valid & ready
//  rsp_chan  out  tangent/bitangent x/y/z Q1.14, degenerate valid & ready
//
//  First and second vertex of a triangle are held in registers.
//  Third vertex starts the sequencer: 14 products, each through S_MISS and S_MACC,
//  then per vector a one-bit-a-cycle normalize shift, three squares, a 31-step
//  square root and three divisions. A zero determinant, or a zero tangent or
//  bitangent, ends the run early with a degenerate result.
//  req_chan.ready is low while the sequencer is busy; a finished result
//  waits in the sequencer until the output register is free or drains.
//  Reset is synchronous and clears corner count, sequencer and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_tangent_basis_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   tbu_req_if.sink    req_chan,
   tbu_rsp_if.source  rsp_chan
);

   logic [1:0]            count_ff, count_in;
   tbu_pkg::vertex_type   c0_ff, c1_ff;
   tbu_pkg::vertex_type   vin;
   tbu_pkg::core_ctl_type ctl;
   tbu_pkg::core_stat_type stat;
   tbu_pkg::result_type   core_res;
   tbu_pkg::result_type   out_ff;
   logic                  out_valid_ff, out_valid_in;
   logic                  req_fire;
   logic                  out_load;

   assign vin.pos_x = req_chan.pos_x;
   assign vin.pos_y = req_chan.pos_y;
   assign vin.pos_z = req_chan.pos_z;
   assign vin.tex_u = req_chan.tex_u;
   assign vin.tex_v = req_chan.tex_v;

   // take vertices only while the sequencer is free
   assign req_chan.ready = stat.idle;
   assign req_fire       = req_chan.valid && stat.idle;

   // third vertex starts the sequencer
   assign ctl.start     = req_fire && (count_ff == 2'd2);
   // output slot is free or drains this cycle
   assign out_load      = stat.done && (!out_valid_ff || rsp_chan.ready);
   assign ctl.out_ready = out_load;

   always_comb begin
      count_in = count_ff;
      if (req_fire) count_in = (count_ff == 2'd2) ? 2'd0 : count_ff + 2'd1;
      out_valid_in = out_valid_ff;
      if (out_load)                         out_valid_in = 1'b1;
      else if (rsp_chan.ready)              out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      // hold the first two corners
      if (req_fire && count_ff == 2'd0) c0_ff <= vin;
      if (req_fire && count_ff == 2'd1) c1_ff <= vin;
      if (out_load) out_ff <= core_res;
   end

   tbu_core u_core (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .c0     (c0_ff),
      .c1     (c1_ff),
      .c2     (vin),
      .stat   (stat),
      .result (core_res)
   );

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.tangent_x   = out_ff.tangent_x;
   assign rsp_chan.tangent_y   = out_ff.tangent_y;
   assign rsp_chan.tangent_z   = out_ff.tangent_z;
   assign rsp_chan.bitangent_x = out_ff.bitangent_x;
   assign rsp_chan.bitangent_y = out_ff.bitangent_y;
   assign rsp_chan.bitangent_z = out_ff.bitangent_z;
   assign rsp_chan.degenerate  = out_ff.degenerate;

endmodule

`default_nettype wire

>>> sv/tbu_mul.sv
// ----------------------------------------------------------------------------
// tbu_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module tbu_mul (
   input  wire logic                              clock,
   input  wire logic signed [tbu_pkg::MUL_W-1:0]  mul_a,
   input  wire logic signed [tbu_pkg::MUL_W-1:0]  mul_b,
   output logic signed      [tbu_pkg::PROD_W-1:0] prod_ff
);

   logic signed [tbu_pkg::PROD_W-1:0] prod_in;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

>>> sv/tbu_core.sv
// ----------------------------------------------------------------------------
// tbu_core
// Sequencer: products, sign fix, normalize shift, squares, square root and
// per-component division; products and squares share one multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module tbu_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire tbu_pkg::core_ctl_type  ctl,
   input  wire tbu_pkg::vertex_type    c0,
   input  wire tbu_pkg::vertex_type    c1,
   input  wire tbu_pkg::vertex_type    c2,
   output tbu_pkg::core_stat_type      stat,
   output tbu_pkg::result_type         result
);

   localparam int DW = tbu_pkg::DIFF_W;
   localparam int VW = tbu_pkg::VEC_W;
   localparam int MW = tbu_pkg::MAG_W;
   localparam int NW = tbu_pkg::NORM_W;
   localparam int LW = tbu_pkg::L2_W;
   localparam int RW = tbu_pkg::REM_W;
   localparam int QW = tbu_pkg::QUO_W;
   localparam int OW = tbu_pkg::OUT_W;
   localparam int SW = tbu_pkg::STEP_W;

   typedef enum logic [11:0] {
      S_IDLE  = 12'b0000_0000_0001,
      S_MISS  = 12'b0000_0000_0010,
      S_MACC  = 12'b0000_0000_0100,
      S_SIGN  = 12'b0000_0000_1000,
      S_NMAG  = 12'b0000_0001_0000,
      S_NSHF  = 12'b0000_0010_0000,
      S_SQISS = 12'b0000_0100_0000,
      S_SQACC = 12'b0000_1000_0000,
      S_SQRT  = 12'b0001_0000_0000,
      S_DSET  = 12'b0010_0000_0000,
      S_DIV   = 12'b0100_0000_0000,
      S_DONE  = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic signed [DW-1:0] e0_ff [3];
   logic signed [DW-1:0] e0_in [3];
   logic signed [DW-1:0] e1_ff [3];
   logic signed [DW-1:0] e1_in [3];
   logic signed [DW-1:0] du0_ff, du0_in, dv0_ff, dv0_in;
   logic signed [DW-1:0] du1_ff, du1_in, dv1_ff, dv1_in;
   logic [tbu_pkg::PIDX_W-1:0] pidx_ff, pidx_in;
   logic signed [VW-1:0] acc_ff, acc_in;
   logic signed [VW-1:0] det_ff, det_in;
   logic signed [VW-1:0] vec_ff [2][3];
   logic signed [VW-1:0] vec_in [2][3];
   logic                 degen_ff, degen_in;
   logic                 vsel_ff, vsel_in;
   logic [MW-1:0]        mag_ff [3];
   logic [MW-1:0]        mag_in [3];
   logic [MW-1:0]        max_ff, max_in;
   logic [1:0]           idx_ff, idx_in;
   logic [LW-1:0]        l2_ff, l2_in;
   logic [LW-1:0]        sx_ff, sx_in;
   logic [LW-1:0]        sr_ff, sr_in;
   logic [SW-1:0]        step_ff, step_in;
   logic [RW-1:0]        rem_ff, rem_in;
   logic [QW-1:0]        quo_ff, quo_in;
   logic signed [OW-1:0] res_ff [2][3];
   logic signed [OW-1:0] res_in [2][3];

   logic signed [tbu_pkg::MUL_W-1:0]  mul_a, mul_b;
   logic signed [tbu_pkg::PROD_W-1:0] prod_ff;
   logic signed [VW-1:0] prod_v;
   logic signed [VW-1:0] diff_v;
   logic [MW-1:0]        abs_v [3];
   logic [MW-1:0]        abs_max;
   logic [LW-1:0]        bit_v;
   logic [LW:0]          trial;
   logic [RW-1:0]        dcmp;
   logic [QW-1:0]        qfin;
   logic [OW-1:0]        qmag;
   logic signed [VW-1:0] vcur;

   function automatic logic signed [tbu_pkg::MUL_W-1:0] sx(logic signed [DW-1:0] x);
      return {{(tbu_pkg::MUL_W-DW){x[DW-1]}}, x};
   endfunction

   tbu_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == S_SQISS) begin
         mul_a = tbu_pkg::MUL_W'(mag_ff[idx_ff][NW-1:0]);
         mul_b = tbu_pkg::MUL_W'(mag_ff[idx_ff][NW-1:0]);
      end else begin
         case (pidx_ff)
            4'd0:  begin mul_a = sx(du0_ff); mul_b = sx(dv1_ff);   end
            4'd1:  begin mul_a = sx(du1_ff); mul_b = sx(dv0_ff);   end
            4'd2:  begin mul_a = sx(dv1_ff); mul_b = sx(e0_ff[0]); end
            4'd3:  begin mul_a = sx(dv0_ff); mul_b = sx(e1_ff[0]); end
            4'd4:  begin mul_a = sx(du0_ff); mul_b = sx(e1_ff[0]); end
            4'd5:  begin mul_a = sx(du1_ff); mul_b = sx(e0_ff[0]); end
            4'd6:  begin mul_a = sx(dv1_ff); mul_b = sx(e0_ff[1]); end
            4'd7:  begin mul_a = sx(dv0_ff); mul_b = sx(e1_ff[1]); end
            4'd8:  begin mul_a = sx(du0_ff); mul_b = sx(e1_ff[1]); end
            4'd9:  begin mul_a = sx(du1_ff); mul_b = sx(e0_ff[1]); end
            4'd10: begin mul_a = sx(dv1_ff); mul_b = sx(e0_ff[2]); end
            4'd11: begin mul_a = sx(dv0_ff); mul_b = sx(e1_ff[2]); end
            4'd12: begin mul_a = sx(du0_ff); mul_b = sx(e1_ff[2]); end
            default: begin mul_a = sx(du1_ff); mul_b = sx(e0_ff[2]); end
         endcase
      end
   end

   assign prod_v = prod_ff[VW-1:0];
   assign diff_v = acc_ff - prod_v;
   assign vcur   = vec_ff[vsel_ff][idx_ff];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         abs_v[i] = vec_ff[vsel_ff][i][VW-1] ? MW'(-vec_ff[vsel_ff][i])
                                            : MW'(vec_ff[vsel_ff][i]);
      end
      abs_max = abs_v[0];
      if (abs_v[1] > abs_max) abs_max = abs_v[1];
      if (abs_v[2] > abs_max) abs_max = abs_v[2];
   end

   assign bit_v = LW'(1) << {step_ff, 1'b0};
   assign trial = {1'b0, sr_ff} + {1'b0, bit_v};
   assign dcmp  = RW'(sr_ff[tbu_pkg::LEN_W-1:0]) << step_ff;

   always_comb begin
      qfin = quo_ff;
      if (rem_ff >= dcmp) qfin[step_ff[3:0]] = 1'b1;
      qmag = (qfin > QW'(tbu_pkg::ONE_Q14)) ? OW'(tbu_pkg::ONE_Q14) : OW'(qfin);
   end

   always_comb begin
      state_in = state_ff;
      e0_in    = e0_ff;
      e1_in    = e1_ff;
      du0_in   = du0_ff;
      dv0_in   = dv0_ff;
      du1_in   = du1_ff;
      dv1_in   = dv1_ff;
      pidx_in  = pidx_ff;
      acc_in   = acc_ff;
      det_in   = det_ff;
      vec_in   = vec_ff;
      degen_in = degen_ff;
      vsel_in  = vsel_ff;
      mag_in   = mag_ff;
      max_in   = max_ff;
      idx_in   = idx_ff;
      l2_in    = l2_ff;
      sx_in    = sx_ff;
      sr_in    = sr_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      res_in   = res_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               for (int i = 0; i < 3; i++) begin
                  e0_in[i] = DW'(tbu_pkg::pos_of(c1, i)) - DW'(tbu_pkg::pos_of(c0, i));
                  e1_in[i] = DW'(tbu_pkg::pos_of(c2, i)) - DW'(tbu_pkg::pos_of(c0, i));
               end
               du0_in   = $signed({1'b0, c1.tex_u}) - $signed({1'b0, c0.tex_u});
               dv0_in   = $signed({1'b0, c1.tex_v}) - $signed({1'b0, c0.tex_v});
               du1_in   = $signed({1'b0, c2.tex_u}) - $signed({1'b0, c0.tex_u});
               dv1_in   = $signed({1'b0, c2.tex_v}) - $signed({1'b0, c0.tex_v});
               pidx_in  = '0;
               degen_in = 1'b0;
               state_in = S_MISS;
            end
         end
         S_MISS: state_in = S_MACC;
         S_MACC: begin
            // even products open a pair, odd ones close it into its target
            if (!pidx_ff[0]) begin
               acc_in = prod_v;
            end else begin
               case (pidx_ff[3:1])
                  3'd0:    det_in       = diff_v;
                  3'd1:    vec_in[0][0] = diff_v;
                  3'd2:    vec_in[1][0] = diff_v;
                  3'd3:    vec_in[0][1] = diff_v;
                  3'd4:    vec_in[1][1] = diff_v;
                  3'd5:    vec_in[0][2] = diff_v;
                  default: vec_in[1][2] = diff_v;
               endcase
            end
            pidx_in  = pidx_ff + 1'b1;
            state_in = (pidx_ff == tbu_pkg::PIDX_W'(tbu_pkg::PROD_LAST)) ? S_SIGN : S_MISS;
         end
         S_SIGN: begin
            if (det_ff < 0) begin
               for (int v = 0; v < 2; v++)
                  for (int i = 0; i < 3; i++)
                     vec_in[v][i] = -vec_ff[v][i];
            end
            vsel_in = 1'b0;
            if (det_ff == '0) begin
               degen_in = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_NMAG;
            end
         end
         S_NMAG: begin
            mag_in = abs_v;
            max_in = abs_max;
            if (abs_max == '0) begin
               degen_in = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_NSHF;
            end
         end
         S_NSHF: begin
            // one bit a cycle until the largest lies in [2^29, 2^30)
            if (|max_ff[MW-1:NW]) begin
               max_in = max_ff >> 1;
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 1;
            end else if (!max_ff[NW-1]) begin
               max_in = max_ff << 1;
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] << 1;
            end else begin
               idx_in   = '0;
               l2_in    = '0;
               state_in = S_SQISS;
            end
         end
         S_SQISS: state_in = S_SQACC;
         S_SQACC: begin
            l2_in = l2_ff + LW'(prod_ff[2*NW-1:0]);
            if (idx_ff == 2'd2) begin
               sx_in    = l2_ff + LW'(prod_ff[2*NW-1:0]);
               sr_in    = '0;
               step_in  = SW'(tbu_pkg::SQRT_TOP);
               state_in = S_SQRT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SQISS;
            end
         end
         S_SQRT: begin
            if ({1'b0, sx_ff} >= trial) begin
               sx_in = sx_ff - trial[LW-1:0];
               sr_in = (sr_ff >> 1) + bit_v;
            end else begin
               sr_in = sr_ff >> 1;
            end
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               idx_in   = '0;
               state_in = S_DSET;
            end
         end
         S_DSET: begin
            rem_in   = {RW'(mag_ff[idx_ff][NW-1:0]) << tbu_pkg::ONE_SHIFT}
                       + RW'(sr_ff[tbu_pkg::LEN_W-1:1]);
            quo_in   = '0;
            step_in  = SW'(tbu_pkg::DIV_TOP);
            state_in = S_DIV;
         end
         S_DIV: begin
            if (rem_ff >= dcmp) rem_in = rem_ff - dcmp;
            quo_in  = qfin;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               res_in[vsel_ff][idx_ff] = vcur[VW-1] ? -$signed(qmag) : $signed(qmag);
               if (idx_ff != 2'd2) begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_DSET;
               end else if (!vsel_ff) begin
                  vsel_in  = 1'b1;
                  state_in = S_NMAG;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (ctl.out_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      e0_ff    <= e0_in;
      e1_ff    <= e1_in;
      du0_ff   <= du0_in;
      dv0_ff   <= dv0_in;
      du1_ff   <= du1_in;
      dv1_ff   <= dv1_in;
      pidx_ff  <= pidx_in;
      acc_ff   <= acc_in;
      det_ff   <= det_in;
      vec_ff   <= vec_in;
      degen_ff <= degen_in;
      vsel_ff  <= vsel_in;
      mag_ff   <= mag_in;
      max_ff   <= max_in;
      idx_ff   <= idx_in;
      l2_ff    <= l2_in;
      sx_ff    <= sx_in;
      sr_ff    <= sr_in;
      step_ff  <= step_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      res_ff   <= res_in;
   end

   assign stat.idle = (state_ff == S_IDLE);
   assign stat.done = (state_ff == S_DONE);

   assign result.tangent_x   = degen_ff ? '0 : res_ff[0][0];
   assign result.tangent_y   = degen_ff ? '0 : res_ff[0][1];
   assign result.tangent_z   = degen_ff ? '0 : res_ff[0][2];
   assign result.bitangent_x = degen_ff ? '0 : res_ff[1][0];
   assign result.bitangent_y = degen_ff ? '0 : res_ff[1][1];
   assign result.bitangent_z = degen_ff ? '0 : res_ff[1][2];
   assign result.degenerate  = degen_ff;

endmodule

`default_nettype wire

>>> sv/tbu_checker.sv
// ----------------------------------------------------------------------------
// tbu_checker
// Port-level checks on the result channel of the tangent basis unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tbu_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic signed [tbu_pkg::OUT_W-1:0] tx,
   input wire logic signed [tbu_pkg::OUT_W-1:0] ty,
   input wire logic signed [tbu_pkg::OUT_W-1:0] tz,
   input wire logic signed [tbu_pkg::OUT_W-1:0] bx,
   input wire logic signed [tbu_pkg::OUT_W-1:0] by,
   input wire logic signed [tbu_pkg::OUT_W-1:0] bz,
   input wire logic                             degen
);

   localparam logic signed [tbu_pkg::OUT_W-1:0] ONE = tbu_pkg::OUT_W'(tbu_pkg::ONE_Q14);

   `ASSERT_CLK(a_reset_clears, clock, reset |=> !rsp_valid)
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(tx) && $stable(bz) && $stable(degen))
   `ASSERT_CLK_RST(a_degen_zero, clock, reset, rsp_valid && degen |-> tx == 0 && ty == 0 && tz == 0 && bx == 0 && by == 0 && bz == 0)
   `ASSERT_CLK_RST(a_unit_range, clock, reset, rsp_valid && !degen |-> tx <= ONE && tx >= -ONE && by <= ONE && by >= -ONE)

endmodule

bind triangle_tangent_basis_unit tbu_checker u_tbu_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .tx        (rsp_chan.tangent_x),
   .ty        (rsp_chan.tangent_y),
   .tz        (rsp_chan.tangent_z),
   .bx        (rsp_chan.bitangent_x),
   .by        (rsp_chan.bitangent_y),
   .bz        (rsp_chan.bitangent_z),
   .degen     (rsp_chan.degenerate)
);

`default_nettype wire
